/* rtl/core/akmps_pkg.sv */
// ============================================================================
// akmps_pkg: shared types and constants for the aligned k-mismatch search
// Field widths, register indexes, reset values and the control bundle that
// the configuration block hands to the search core.
// ============================================================================
`default_nettype none

package akmps_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 64;
    localparam int PAT_BYTES  = 32;
    localparam int PAT_W      = PAT_BYTES * BYTE_W;
    localparam int PAT_IDX_W  = $clog2(PAT_BYTES);
    localparam int OFFSET_W   = 25;
    localparam int POS_W      = 26;
    localparam int LEN_CFG_W  = 6;
    localparam int SPAN_W     = 7;
    localparam int PHASE_W    = 4;
    localparam int CFG_IDX_W  = 3;

    localparam logic [POS_W-1:0]    POS_MAX    = {POS_W{1'b1}};
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

    localparam int DEF_MAX_PATTERN_BYTES = 32;
    localparam int DEF_START_ALIGN       = 4;

    localparam logic [LEN_CFG_W-1:0] PLEN_RST = 6'd30;
    localparam logic [LEN_CFG_W-1:0] MLIM_RST = 6'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT0  = 3'd0,
        CFG_PAT1  = 3'd1,
        CFG_PAT2  = 3'd2,
        CFG_PAT3  = 3'd3,
        CFG_PLEN  = 3'd4,
        CFG_MLIM  = 3'd5,
        CFG_START = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } in_item_t;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
    } out_item_t;

    typedef struct packed {
        logic                 busy;
        logic [SPAN_W-1:0]    span;
        logic [POS_W-1:0]     start_thr;
        logic [POS_W-1:0]     end_thr;
        logic [PHASE_W-1:0]   phase;
        logic [LEN_CFG_W-1:0] limit;
    } cfg_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/akmps_cfg.sv */
// ============================================================================
// akmps_cfg: configuration registers and derived search controls
// Holds the pattern, length, mismatch limit and start offset, registers the
// right-aligned pattern and window mask, and reduces (start + span) modulo
// the start alignment by a reciprocal multiply after reset and after each
// write.
// ============================================================================
`default_nettype none

module akmps_cfg #(
    parameter int MAX_PATTERN_BYTES = akmps_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int START_ALIGN       = akmps_pkg::DEF_START_ALIGN
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        cfg_write,
    input  wire logic [akmps_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  wire logic [akmps_pkg::WORD_W-1:0]                cfg_data,
    output akmps_pkg::cfg_ctl_t                              ctl,
    output logic [MAX_PATTERN_BYTES*akmps_pkg::BYTE_W-1:0]   pattern,
    output logic [MAX_PATTERN_BYTES-1:0]                     mask
);
    import akmps_pkg::*;

    localparam int RED_CYCLES = 3;
    localparam int CNT_W      = $clog2(RED_CYCLES + 1);
    localparam int WIN_W      = MAX_PATTERN_BYTES * BYTE_W;
    localparam int RED_SH     = POS_W + $clog2(START_ALIGN);
    localparam int PROD_W     = 2 * POS_W + 1;
    localparam logic [POS_W:0] RED_MUL =
        (POS_W+1)'(((64'd1 << RED_SH) + 64'(START_ALIGN) - 64'd1) / 64'(START_ALIGN));

    logic [PAT_W-1:0]     pat_reg;
    logic [LEN_CFG_W-1:0] plen_reg;
    logic [LEN_CFG_W-1:0] mlim_reg;
    logic [OFFSET_W-1:0]  start_reg;

    logic [WIN_W-1:0]             aln_reg,       aln_next;
    logic [MAX_PATTERN_BYTES-1:0] msk_reg,       msk_next;
    logic [SPAN_W-1:0]            span_reg,      span_next;
    logic [POS_W-1:0]             start_thr_reg, start_thr_next;
    logic [POS_W-1:0]             end_thr_reg,   end_thr_next;
    logic [LEN_CFG_W-1:0]         limit_reg,     limit_next;
    logic [CNT_W-1:0]             cnt_reg,       cnt_next;
    logic [PHASE_W-1:0]           rem_reg,       rem_next;
    logic [PROD_W-1:0]            prod_reg;
    logic [POS_W-1:0]             thr_d_reg;

    logic [SPAN_W-1:0]  len;
    logic [SPAN_W-1:0]  k;
    logic [POS_W-1:0]   quot;
    logic               busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg   <= '0;
            plen_reg  <= PLEN_RST;
            mlim_reg  <= MLIM_RST;
            start_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PAT0:  pat_reg[0*WORD_W +: WORD_W] <= cfg_data;
                CFG_PAT1:  pat_reg[1*WORD_W +: WORD_W] <= cfg_data;
                CFG_PAT2:  pat_reg[2*WORD_W +: WORD_W] <= cfg_data;
                CFG_PAT3:  pat_reg[3*WORD_W +: WORD_W] <= cfg_data;
                CFG_PLEN:  plen_reg  <= cfg_data[LEN_CFG_W-1:0];
                CFG_MLIM:  mlim_reg  <= cfg_data[LEN_CFG_W-1:0];
                CFG_START: start_reg <= cfg_data[OFFSET_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        len = (SPAN_W'(plen_reg) > SPAN_W'(MAX_PATTERN_BYTES)) ?
              SPAN_W'(MAX_PATTERN_BYTES) : SPAN_W'(plen_reg);
        span_next      = (len == '0) ? SPAN_W'(1) : len;
        start_thr_next = POS_W'(start_reg) + POS_W'(span_next);
        end_thr_next   = POS_W'(OFFSET_MAX) + POS_W'(span_next);
        limit_next     = (mlim_reg == '0) ? LEN_CFG_W'(1) : mlim_reg;
        aln_next       = '0;
        msk_next       = '0;
        k              = '0;
        // window index j lines up with pattern byte len-1-j
        for (int j = 0; j < MAX_PATTERN_BYTES; j++)
        begin
            k = len - SPAN_W'(j) - SPAN_W'(1);
            if (SPAN_W'(j) < len)
            begin
                msk_next[j] = 1'b1;
                if (k < SPAN_W'(PAT_BYTES))
                begin
                    aln_next[j*BYTE_W +: BYTE_W] =
                        pat_reg[BYTE_W*k[PAT_IDX_W-1:0] +: BYTE_W];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        aln_reg       <= aln_next;
        msk_reg       <= msk_next;
        span_reg      <= span_next;
        start_thr_reg <= start_thr_next;
        end_thr_reg   <= end_thr_next;
        limit_reg     <= limit_next;
        prod_reg      <= PROD_W'(start_thr_reg) * PROD_W'(RED_MUL);
        thr_d_reg     <= start_thr_reg;
    end

    // remainder of (start + span): threshold, product, remainder stages
    always_comb
    begin
        busy     = (cnt_reg != CNT_W'(RED_CYCLES));
        quot     = POS_W'(prod_reg >> RED_SH);
        rem_next = PHASE_W'(thr_d_reg - quot * POS_W'(START_ALIGN));
        cnt_next = cnt_reg;
        if (cfg_write)
            cnt_next = '0;
        else if (busy)
            cnt_next = cnt_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rem_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rem_reg <= rem_next;
        end
    end

    assign ctl.busy      = busy;
    assign ctl.span      = span_reg;
    assign ctl.start_thr = start_thr_reg;
    assign ctl.end_thr   = end_thr_reg;
    assign ctl.phase     = rem_reg;
    assign ctl.limit     = limit_reg;
    assign pattern       = aln_reg;
    assign mask          = msk_reg;

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (rem_reg < PHASE_W'(START_ALIGN) || START_ALIGN == 16))
        else $error("phase remainder out of range");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(RED_CYCLES))
        else $error("reduction counter overran");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> busy)
        else $error("config write did not restart phase reduction");

endmodule

`default_nettype wire

/* rtl/core/akmps_core.sv */
// ============================================================================
// akmps_core: byte window, window compare and result register
// Shifts each byte into the window while the search is active, counts
// mismatches against the aligned pattern through an adder tree, checks the
// candidate start and registers the found / not-found result.
// ============================================================================
`default_nettype none

module akmps_core #(
    parameter int MAX_PATTERN_BYTES = akmps_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int START_ALIGN       = akmps_pkg::DEF_START_ALIGN
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        item_valid,
    input  akmps_pkg::in_item_t                              item,
    output logic                                             take,
    input  akmps_pkg::cfg_ctl_t                              ctl,
    input  wire logic [MAX_PATTERN_BYTES*akmps_pkg::BYTE_W-1:0] pattern,
    input  wire logic [MAX_PATTERN_BYTES-1:0]                mask,
    output logic                                             out_valid,
    input  wire logic                                        out_stall,
    output akmps_pkg::out_item_t                             out_data
);
    import akmps_pkg::*;

    localparam int LVLS = $clog2(MAX_PATTERN_BYTES);
    localparam int NP   = 1 << LVLS;

    logic [BYTE_W-1:0]  win_reg [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0]  win_next [MAX_PATTERN_BYTES];
    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic [PHASE_W-1:0] posm_reg,  posm_next;
    logic               done_reg,  done_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg,  out_data_next;

    logic [MAX_PATTERN_BYTES-1:0] mm;
    logic [NP-1:0]                mm_pad;
    logic [SPAN_W-1:0]            tree [LVLS+1][NP];
    logic [SPAN_W-1:0]            diff;
    logic [POS_W-1:0]             p1;
    logic [POS_W-1:0]             s;
    logic [PHASE_W-1:0]           posm_inc;
    logic                         fire;
    logic                         active;
    logic                         cand;
    logic                         hit;
    logic                         produce;

    always_comb
    begin
        take     = !ctl.busy && (!out_valid_reg || !out_stall);
        fire     = item_valid && take;
        active   = !done_reg && (pos_reg != POS_MAX);
        p1       = pos_reg + POS_W'(1);
        s        = p1 - POS_W'(ctl.span);
        posm_inc = (posm_reg == PHASE_W'(START_ALIGN - 1)) ? '0 : posm_reg + PHASE_W'(1);

        win_next[0] = item.data_byte;
        for (int j = 1; j < MAX_PATTERN_BYTES; j++)
            win_next[j] = win_reg[j-1];

        for (int j = 0; j < MAX_PATTERN_BYTES; j++)
            mm[j] = mask[j] && (win_next[j] != pattern[j*BYTE_W +: BYTE_W]);

        mm_pad = NP'(mm);
        tree   = '{default: '{default: '0}};
        for (int k = 0; k < NP; k++)
            tree[0][k] = SPAN_W'(mm_pad[k]);
        for (int l = 1; l <= LVLS; l++)
        begin
            for (int k = 0; k < (NP >> l); k++)
                tree[l][k] = tree[l-1][2*k] + tree[l-1][2*k+1];
        end
        diff = tree[LVLS][0];

        cand    = (p1 >= ctl.start_thr) && (p1 <= ctl.end_thr) && (posm_inc == ctl.phase);
        hit     = active && cand && (diff < SPAN_W'(ctl.limit));
        produce = hit || (item.last_byte && !done_reg);

        pos_next  = pos_reg;
        posm_next = posm_reg;
        done_next = done_reg;
        if (fire)
        begin
            if (active)
            begin
                pos_next  = p1;
                posm_next = posm_inc;
            end
            if (item.last_byte)
            begin
                pos_next  = '0;
                posm_next = '0;
                done_next = 1'b0;
            end
            else if (hit)
            begin
                done_next = 1'b1;
            end
        end

        out_data_next.found        = hit;
        out_data_next.match_offset = hit ? s[OFFSET_W-1:0] : '0;

        if (fire && produce)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            posm_reg      <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            posm_reg      <= posm_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && active)
            win_reg <= win_next;
        if (fire && produce)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_phase_track: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == '0) |-> (posm_reg == '0))
        else $error("phase counter out of step with byte position");

    a_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (pos_reg != '0))
        else $error("search marked done at stream start");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.found) |-> (out_data_reg.match_offset == '0))
        else $error("not-found result carries an offset");

endmodule

`default_nettype wire

/* rtl/core/aligned_k_mismatch_pattern_search_unit.sv */
// ============================================================================
// aligned_k_mismatch_pattern_search_unit: aligned k-mismatch byte search
// Finds the first window of the byte stream, starting at start_offset plus
// a multiple of START_ALIGN, that differs from the pattern in fewer than
// mismatch_limit bytes, and reports it or reports not-found at stream end.
//
//   port group  dir  handshake            payload
//   in          in   in_valid/in_stall    in_item_t   (data_byte, last_byte)
//   out         out  out_valid/out_stall  out_item_t  (found, match_offset)
//   cfg         in   cfg_write            cfg_index, cfg_data
//
// One byte per cycle sustained unless a held result or the phase reduction
// stalls input. The window compare and mismatch adder tree sit between
// input and result registers. After reset and after every cfg write, input
// stalls while the alignment phase is computed by a reciprocal multiply.
// A held result only stalls input once the input register is also full.
// ============================================================================
`default_nettype none

module aligned_k_mismatch_pattern_search_unit #(
    parameter int MAX_PATTERN_BYTES = akmps_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int START_ALIGN       = akmps_pkg::DEF_START_ALIGN
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  akmps_pkg::in_item_t                  in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output akmps_pkg::out_item_t                 out_data,
    input  wire logic                            cfg_write,
    input  wire logic [akmps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [akmps_pkg::WORD_W-1:0]    cfg_data
);
    import akmps_pkg::*;

    cfg_ctl_t                            ctl;
    logic [MAX_PATTERN_BYTES*BYTE_W-1:0] pattern;
    logic [MAX_PATTERN_BYTES-1:0]        mask;
    logic                                take;
    logic                                accept;
    logic                                stg_valid_reg, stg_valid_next;
    in_item_t                            stg_item_reg;

    akmps_cfg #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .START_ALIGN       (START_ALIGN)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .pattern   (pattern),
        .mask      (mask)
    );

    akmps_core #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .START_ALIGN       (START_ALIGN)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (stg_valid_reg),
        .item       (stg_item_reg),
        .take       (take),
        .ctl        (ctl),
        .pattern    (pattern),
        .mask       (mask),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    always_comb
    begin
        in_stall = ctl.busy || (stg_valid_reg && !take);
        accept   = in_valid && !in_stall;
        if (accept)
            stg_valid_next = 1'b1;
        else if (take)
            stg_valid_next = 1'b0;
        else
            stg_valid_next = stg_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else
            stg_valid_reg <= stg_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stg_item_reg <= in_data;
    end

endmodule

`default_nettype wire
